// ===== src/sprd_pkg.sv =====
// Shared types, codes and helpers for the supply presence debouncer.
package sprd_pkg;

  localparam int EVENT_SLOTS_DEF = 16;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd500;

  localparam logic [1:0] CMD_ATTACH  = 2'd0;
  localparam logic [1:0] CMD_REMOVAL = 2'd1;
  localparam logic [1:0] CMD_SERVICE = 2'd2;

  localparam logic [1:0] REG_OFF_HALF   = 2'd0;
  localparam logic [1:0] REG_OFF_STABLE = 2'd1;
  localparam logic [1:0] REG_ON_STABLE  = 2'd2;

  localparam logic [2:0] PH_ON_NEW     = 3'd0;
  localparam logic [2:0] PH_ON_STABLE  = 3'd1;
  localparam logic [2:0] PH_OFF_NEW    = 3'd2;
  localparam logic [2:0] PH_OFF_HALF   = 3'd3;
  localparam logic [2:0] PH_OFF_STABLE = 3'd4;

  localparam logic [4:0] COUNT_MAX = 5'd31;

  typedef struct packed {
    logic wr_en;
    logic wr_removal;
    logic rd_en;
    logic drain;
  } sprd_ring_ctrl_t;

  typedef struct packed {
    logic        load_elapsed;
    logic        eval;
    logic        drained;
    logic        last_removal;
    logic [4:0]  drain_count;
    logic        present;
    logic [31:0] now;
  } sprd_eval_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [4:0] count;
    logic       missed;
    logic       irq_disable;
  } sprd_result_t;

  function automatic logic [4:0] bump(input logic [4:0] n);
    return (n < COUNT_MAX) ? n + 5'd1 : COUNT_MAX;
  endfunction

endpackage

// ===== src/sprd_ring.sv =====
// Event ring: synchronous event memory with write pointer and fill count.
module sprd_ring #(
  parameter int EVENT_SLOTS = sprd_pkg::EVENT_SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sprd_pkg::sprd_ring_ctrl_t ctrl,
  output logic                      full,
  output logic                      pending,
  output logic [4:0]                drain_count,
  output logic                      rd_removal
);
  import sprd_pkg::*;

  localparam int AW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int FW = $clog2(EVENT_SLOTS + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(EVENT_SLOTS - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(EVENT_SLOTS);

  logic            mem [EVENT_SLOTS];
  logic [AW-1:0]   wr_ptr;
  logic [FW-1:0]   fill;
  logic [AW-1:0]   newest;
  logic [31:0]     fill_ext;

  assign full     = (fill == FILL_FULL);
  assign pending  = (fill != '0);
  assign fill_ext = 32'(fill);
  assign drain_count = (fill_ext > 32'd31) ? COUNT_MAX : fill_ext[4:0];
  // newest entry sits just behind the write pointer
  assign newest   = (wr_ptr == '0) ? LAST_SLOT : wr_ptr - AW'(1);

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_ptr] <= ctrl.wr_removal;
    end
    if (ctrl.rd_en) begin
      rd_removal <= mem[newest];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      fill   <= '0;
    end else if (ctrl.drain) begin
      fill <= '0;
    end else if (ctrl.wr_en) begin
      wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + AW'(1);
      fill   <= fill + FW'(1);
    end
  end

endmodule

// ===== src/sprd_phase.sv =====
// Supply phase tracker: event replay, live status check and debounce timing.
module sprd_phase (
  input  logic                    clk,
  input  logic                    rst,
  input  sprd_pkg::sprd_eval_t    ev,
  input  logic [15:0]             off_half_ms,
  input  logic [15:0]             off_stable_ms,
  input  logic [15:0]             on_stable_ms,
  output logic [2:0]              cur_phase,
  output sprd_pkg::sprd_result_t  res
);
  import sprd_pkg::*;

  logic [2:0]  phase;
  logic [31:0] last_change;
  logic [31:0] elapsed;
  logic [15:0] limit;
  logic        timed_out;

  assign cur_phase = phase;

  always_comb begin
    res.phase       = phase;
    res.count       = '0;
    res.missed      = 1'b0;
    res.irq_disable = 1'b0;
    limit           = '0;
    timed_out       = 1'b0;
    if (ev.drained) begin
      res.phase = ev.last_removal ? PH_OFF_NEW : PH_ON_NEW;
      res.count = ev.drain_count;
    end
    if (res.phase == PH_ON_NEW || res.phase == PH_ON_STABLE) begin
      if (!ev.present) begin
        res.phase       = PH_OFF_NEW;
        res.count       = bump(res.count);
        res.missed      = 1'b1;
        res.irq_disable = 1'b1;
      end
    end else if (ev.present) begin
      res.phase  = PH_ON_NEW;
      res.count  = bump(res.count);
      res.missed = 1'b1;
    end
    if (res.count == '0) begin
      case (res.phase)
        PH_OFF_NEW:  limit = off_half_ms;
        PH_OFF_HALF: limit = off_stable_ms;
        PH_ON_NEW:   limit = on_stable_ms;
        default:     limit = '0;
      endcase
      timed_out = (limit != '0) &&
                  ((elapsed[31:16] != '0) || (elapsed[15:0] >= limit));
      if (timed_out) begin
        res.phase = res.phase + 3'd1;
        res.count = 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev.load_elapsed) begin
      elapsed <= ev.now - last_change;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_ON_NEW;
      last_change <= '0;
    end else if (ev.eval) begin
      phase <= res.phase;
      if (res.count != '0) begin
        last_change <= ev.now;
      end
    end
  end

endmodule

// ===== src/supply_presence_debouncer_core.sv =====
// Supply presence debouncer top level: stream ports, sequencer, registers.
// Sequence: a record item or an unused command passes execute and output;
//   a service pass passes execute, evaluate and output, the evaluate step
//   using the newest event fetched from the event memory in execute. One
//   item at a time: a new item is taken only once the last result is output.
// Reset: synchronous, active high; empties the ring, phase on_new, change
//   stamp zero, all three debounce registers 500 ms, no result pending.
module supply_presence_debouncer_core #(
  parameter int EVENT_SLOTS = sprd_pkg::EVENT_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] now_ms, [32] supply_present, zero pad
  input  logic [1:0]  s_tuser,   // [1:0] command
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] supply_state, [7:3] change_count,
                                 // [8] missed_edge, [9] event_accepted,
                                 // [10] events_pending, [11] io_irq_disable
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sprd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_EVAL = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  // debounce registers
  logic [15:0] off_half_ms;
  logic [15:0] off_stable_ms;
  logic [15:0] on_stable_ms;
  logic        cfg_write;

  // latched item
  logic [1:0]  cmd;
  logic [31:0] now;
  logic        present;
  logic        drained;

  // finished result, waiting for the output register
  logic [2:0]  res_state;
  logic [4:0]  res_count;
  logic        res_missed;
  logic        res_accepted;
  logic        res_pending;
  logic        res_irq;

  sprd_ring_ctrl_t ring_ctrl;
  sprd_eval_t      eval_ctrl;
  sprd_result_t    eval_res;
  logic            ring_full;
  logic            ring_pending;
  logic [4:0]      ring_count;
  logic            ring_removal;
  logic [2:0]      cur_phase;
  logic            is_record;
  logic            out_free;

  // ---------------------------------------------------------------------------
  // Configuration: writes land on the access cycle; reads are combinational.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      off_half_ms   <= DEBOUNCE_RESET;
      off_stable_ms <= DEBOUNCE_RESET;
      on_stable_ms  <= DEBOUNCE_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_OFF_HALF:   off_half_ms   <= pwdata[15:0];
        REG_OFF_STABLE: off_stable_ms <= pwdata[15:0];
        REG_ON_STABLE:  on_stable_ms  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_OFF_HALF:   prdata = {16'd0, off_half_ms};
      REG_OFF_STABLE: prdata = {16'd0, off_stable_ms};
      REG_ON_STABLE:  prdata = {16'd0, on_stable_ms};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: one item at a time; the output register lets the next transfer
  // in while a result still waits downstream. Hold off transfers during reset.
  // ---------------------------------------------------------------------------
  assign s_tready  = (state == ST_IDLE) && !rst;
  assign out_free  = !m_tvalid || m_tready;
  assign is_record = (cmd == CMD_ATTACH) || (cmd == CMD_REMOVAL);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
      ST_EXEC: state_next = (cmd == CMD_SERVICE) ? ST_EVAL : ST_DONE;
      ST_EVAL: state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // latch the item on its transfer
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd     <= s_tuser;
      now     <= s_tdata[31:0];
      present <= s_tdata[32];
    end
    if (state == ST_EXEC) begin
      drained <= ring_pending;
    end
  end

  // ring: write on a record with room, fetch the newest event and empty the
  // ring on a service pass
  always_comb begin
    ring_ctrl.wr_en      = (state == ST_EXEC) && is_record && !ring_full;
    ring_ctrl.wr_removal = (cmd == CMD_REMOVAL);
    ring_ctrl.rd_en      = (state == ST_EXEC) && (cmd == CMD_SERVICE) && ring_pending;
    ring_ctrl.drain      = (state == ST_EVAL) && drained;
  end

  sprd_ring #(
    .EVENT_SLOTS (EVENT_SLOTS)
  ) u_ring (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ring_ctrl),
    .full        (ring_full),
    .pending     (ring_pending),
    .drain_count (ring_count),
    .rd_removal  (ring_removal)
  );

  // phase: take the elapsed time in execute, settle the phase in evaluate;
  // only the newest drained event decides where replay leaves the phase
  always_comb begin
    eval_ctrl.load_elapsed = (state == ST_EXEC);
    eval_ctrl.eval         = (state == ST_EVAL);
    eval_ctrl.drained      = drained;
    eval_ctrl.last_removal = ring_removal;
    eval_ctrl.drain_count  = ring_count;
    eval_ctrl.present      = present;
    eval_ctrl.now          = now;
  end

  sprd_phase u_phase (
    .clk           (clk),
    .rst           (rst),
    .ev            (eval_ctrl),
    .off_half_ms   (off_half_ms),
    .off_stable_ms (off_stable_ms),
    .on_stable_ms  (on_stable_ms),
    .cur_phase     (cur_phase),
    .res           (eval_res)
  );

  // build the result: records and unused commands in execute, service in
  // evaluate (the ring count is still valid there, drain lands at its edge)
  always_ff @(posedge clk) begin
    if (state == ST_EXEC && cmd != CMD_SERVICE) begin
      res_state    <= cur_phase;
      res_count    <= '0;
      res_missed   <= 1'b0;
      res_irq      <= 1'b0;
      res_accepted <= is_record && !ring_full;
      res_pending  <= ring_pending || (is_record && !ring_full);
    end else if (state == ST_EVAL) begin
      res_state    <= eval_res.phase;
      res_count    <= eval_res.count;
      res_missed   <= eval_res.missed;
      res_irq      <= eval_res.irq_disable;
      res_accepted <= 1'b0;
      res_pending  <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold until the result transfer completes.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {4'd0, res_irq, res_pending, res_accepted, res_missed,
                  res_count, res_state};
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the supply presence debouncer core.
`timescale 1ns / 100ps

module testbench;
  import sprd_pkg::*;

  localparam int SLOTS = EVENT_SLOTS_DEF;
  localparam int SLOT_AW = $clog2(SLOTS);
  // Command code 3 has no meaning; the block must leave everything as it is.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Long receiver hold-off, in cycles, that lets the block fill up and stall.
  localparam int HOLD_CYCLES = 400;
  // Hard stop: many times the slowest correct run.
  localparam longint RUN_LIMIT_NS = 64'd10_000_000;

  typedef enum logic [1:0] {
    EV_EMPTY   = 2'd0,
    EV_ATTACH  = 2'd1,
    EV_REMOVAL = 2'd2
  } event_code_t;

  // Result word as it travels on m_tdata, last field in the lowest bits.
  typedef struct packed {
    logic [3:0] pad;
    logic       irq_disable;
    logic       pending;
    logic       accepted;
    logic       missed;
    logic [4:0] count;
    logic [2:0] state;
  } status_word_t;

  // One input item, with an optional hand-written expectation.
  typedef struct {
    logic [1:0]   cmd;
    logic [31:0]  now;
    logic         present;
    logic         typed;
    status_word_t want;
  } supply_item_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // [31:0] now_ms, [32] supply_present, zero pad
  logic [1:0]  s_tuser;   // [1:0] command
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [2:0] state, [7:3] count, [8] missed, [9] accepted,
                          // [10] pending, [11] io_irq_disable
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Pressure control: the request and the hold both move by nonblocking
  // assignment so no process sees them change mid-step.
  logic squeeze_req = 1'b0;
  logic hold_rx     = 1'b0;
  bit   idle_on     = 1'b1;

  // Mirror of the block's state, kept by the predictor.
  event_code_t        slot_ring [SLOTS];
  logic [SLOT_AW-1:0] rd_slot;
  logic [SLOT_AW-1:0] wr_slot;
  logic [2:0]         phase_now;
  logic [31:0]        change_stamp;
  logic [15:0]        dly_off_half;
  logic [15:0]        dly_off_stable;
  logic [15:0]        dly_on_stable;

  supply_item_t item_q[$];
  status_word_t status_due_q[$];
  int           mismatches = 0;
  int           results_seen = 0;

  // Stimulus shaping state for the random part.
  logic [31:0] clock_ms = 32'd0;
  logic        live = 1'b1;

  supply_presence_debouncer_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic void clear_mirror();
    slot_ring      = '{default: EV_EMPTY};
    rd_slot        = '0;
    wr_slot        = '0;
    phase_now      = PH_ON_NEW;
    change_stamp   = 32'd0;
    dly_off_half   = DEBOUNCE_RESET;
    dly_off_stable = DEBOUNCE_RESET;
    dly_on_stable  = DEBOUNCE_RESET;
  endfunction

  // Advance a slot pointer round the ring.
  function automatic logic [SLOT_AW-1:0] next_slot(input logic [SLOT_AW-1:0] s);
    return (s == SLOT_AW'(SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  // Work out the status word that one accepted item produces and advance
  // the mirrored state.
  function automatic status_word_t debounce_step(input logic [1:0] cmd,
                                                 input logic [31:0] now,
                                                 input logic present);
    status_word_t w;
    int           changes;
    logic [15:0]  limit;
    logic [31:0]  elapsed;
    w       = '0;
    changes = 0;
    if (cmd == CMD_ATTACH || cmd == CMD_REMOVAL) begin
      // Occupied write slot: drop the event, leave everything else alone.
      if (slot_ring[wr_slot] == EV_EMPTY) begin
        if (cmd == CMD_ATTACH) slot_ring[wr_slot] = EV_ATTACH;
        else slot_ring[wr_slot] = EV_REMOVAL;
        wr_slot    = next_slot(wr_slot);
        w.accepted = 1'b1;
      end
    end else if (cmd == CMD_SERVICE) begin
      // Drain the ring in order; the newest event decides the phase.
      for (int g = 0; g < SLOTS && slot_ring[rd_slot] != EV_EMPTY; g++) begin
        if (slot_ring[rd_slot] == EV_REMOVAL) phase_now = PH_OFF_NEW;
        else phase_now = PH_ON_NEW;
        slot_ring[rd_slot] = EV_EMPTY;
        rd_slot = next_slot(rd_slot);
        if (changes < 31) changes++;
      end
      // Live status against phase: catch an edge the interrupts missed.
      if (phase_now == PH_ON_NEW || phase_now == PH_ON_STABLE) begin
        if (!present) begin
          phase_now     = PH_OFF_NEW;
          w.missed      = 1'b1;
          w.irq_disable = 1'b1;
          if (changes < 31) changes++;
        end
      end else if (present) begin
        phase_now = PH_ON_NEW;
        w.missed  = 1'b1;
        if (changes < 31) changes++;
      end
      // Quiet pass: advance by time; a zero delay never advances.
      if (changes == 0) begin
        limit = 16'd0;
        if (phase_now == PH_OFF_NEW) limit = dly_off_half;
        else if (phase_now == PH_OFF_HALF) limit = dly_off_stable;
        else if (phase_now == PH_ON_NEW) limit = dly_on_stable;
        elapsed = now - change_stamp;
        if (limit != 16'd0 && elapsed >= {16'd0, limit}) begin
          phase_now = phase_now + 3'd1;
          changes   = 1;
        end
      end
      if (changes != 0) change_stamp = now;
    end
    w.state   = phase_now;
    w.count   = changes[4:0];
    w.pending = (slot_ring[rd_slot] != EV_EMPTY);
    return w;
  endfunction

  function automatic status_word_t word(input logic [2:0] state, input int count,
                                        input logic missed, input logic accepted,
                                        input logic pending, input logic irq_disable);
    status_word_t w;
    w             = '0;
    w.state       = state;
    w.count       = count[4:0];
    w.missed      = missed;
    w.accepted    = accepted;
    w.pending     = pending;
    w.irq_disable = irq_disable;
    return w;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  task automatic push_row(input logic [1:0] cmd, input logic [31:0] now,
                          input logic present, input logic typed,
                          input status_word_t want);
    supply_item_t it;
    it.cmd     = cmd;
    it.now     = now;
    it.present = present;
    it.typed   = typed;
    it.want    = want;
    item_q.push_back(it);
  endtask

  // Most gaps are short, a few are long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Advance the millisecond clock: mostly around the debounce delays,
  // sometimes by almost nothing, now and then by a jump that wraps.
  function automatic void tick_clock();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) clock_ms = clock_ms + $urandom_range(0, 600);
    else if (r < 80) clock_ms = clock_ms + $urandom_range(0, 70000);
    else if (r < 95) clock_ms = clock_ms + $urandom_range(0, 3);
    else clock_ms = $urandom;
  endfunction

  // Live status follows the last recorded event, with the odd contradiction
  // to provoke missed edges.
  function automatic logic sampled_presence();
    return live ^ ($urandom_range(0, 9) == 0);
  endfunction

  // Mostly well-formed traffic: bursts of events closed by a service pass,
  // and runs of service passes that let the debounce timers expire.
  task automatic queue_random(input int n);
    int         made;
    int         burst;
    int         r;
    logic [1:0] c;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        burst = ($urandom_range(0, 19) == 0) ? $urandom_range(14, 20)
                                             : $urandom_range(1, 3);
        for (int k = 0; k < burst; k++) begin
          c    = ($urandom_range(0, 1) != 0) ? CMD_REMOVAL : CMD_ATTACH;
          live = (c == CMD_ATTACH);
          tick_clock();
          push_row(c, clock_ms, sampled_presence(), 1'b0, '0);
        end
        tick_clock();
        push_row(CMD_SERVICE, clock_ms, sampled_presence(), 1'b0, '0);
        made += burst + 1;
      end else if (r < 88) begin
        tick_clock();
        push_row(CMD_SERVICE, clock_ms, sampled_presence(), 1'b0, '0);
        made++;
      end else if (r < 94) begin
        // Ignored by the block, so not counted.
        push_row(CMD_UNUSED, $urandom, 1'($urandom_range(0, 1)), 1'b0, '0);
      end else begin
        push_row(2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)),
                 1'b0, '0);
        made++;
      end
    end
  endtask

  // Offer every queued item; keep tvalid high across back-to-back transfers.
  task automatic push_items();
    supply_item_t it;
    status_word_t w;
    int           g;
    while (item_q.size() > 0) begin
      it = item_q.pop_front();
      g  = (idle_on && !hold_rx && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (g > 0) begin
        s_tvalid <= 1'b0;
        repeat (g) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= {7'd0, it.present, it.now};
      s_tuser  <= it.cmd;
      do @(posedge clk); while (!s_tready);
      w = debounce_step(it.cmd, it.now, it.present);
      if (it.typed) w = it.want;
      status_due_q.push_back(w);
    end
    s_tvalid <= 1'b0;
  endtask

  // Register write: setup, then access.
  task automatic write_debounce(input logic [1:0] idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_OFF_HALF:   dly_off_half   = value;
      REG_OFF_STABLE: dly_off_stable = value;
      REG_ON_STABLE:  dly_on_stable  = value;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (status_due_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stalls, plus the long hold-off while hold_rx is up
  // ---------------------------------------------------------------------
  initial begin
    int rx_wait;
    rx_wait = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_wait > 0) rx_wait--;
      else if (idle_on && $urandom_range(0, 5) == 0) rx_wait = pick_gap();
      m_tready <= !hold_rx && (rx_wait == 0);
    end
  end

  // Count out the long hold-off once it is asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        squeeze_req <= 1'b0;
        hold_rx     <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx     <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checker: every result transfer against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    status_word_t want;
    status_word_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = status_word_t'(m_tdata);
      results_seen++;
      if (status_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result %0d arrived with nothing expected, data %h",
                   $realtime, results_seen, m_tdata);
      end else begin
        want = status_due_q.pop_front();
        if (got.state !== want.state || got.count !== want.count ||
            got.missed !== want.missed || got.accepted !== want.accepted ||
            got.pending !== want.pending || got.irq_disable !== want.irq_disable) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result %0d expected/actual: state %0d/%0d count %0d/%0d",
                     $realtime, results_seen, want.state, got.state,
                     want.count, got.count);
            $display("  missed %b/%b accepted %b/%b pending %b/%b irq %b/%b",
                     want.missed, got.missed, want.accepted, got.accepted,
                     want.pending, got.pending, want.irq_disable, got.irq_disable);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Hard stop
  // ---------------------------------------------------------------------
  initial begin
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [15:0] cfg [3];
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= CMD_ATTACH;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    clear_mirror();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed table, reset delays of 500 ms throughout.
    // Quiet pass at time zero: nothing to do.
    push_row(CMD_SERVICE, 32'd0, 1'b1, 1'b1, word(PH_ON_NEW, 0, 0, 0, 0, 0));
    // Attach debounce expires exactly at the delay.
    push_row(CMD_SERVICE, 32'd500, 1'b1, 1'b1, word(PH_ON_STABLE, 1, 0, 0, 0, 0));
    // Supply gone with no removal event: missed removal, ask to mask brownout.
    push_row(CMD_SERVICE, 32'd600, 1'b0, 1'b1, word(PH_OFF_NEW, 1, 1, 0, 0, 1));
    push_row(CMD_SERVICE, 32'd1100, 1'b0, 1'b1, word(PH_OFF_HALF, 1, 0, 0, 0, 0));
    push_row(CMD_SERVICE, 32'hFFFF_FFFF, 1'b0, 1'b1,
             word(PH_OFF_STABLE, 1, 0, 0, 0, 0));
    // Supply back with no attach event: missed attach, no brownout request.
    push_row(CMD_SERVICE, 32'hFFFF_FF00, 1'b1, 1'b1, word(PH_ON_NEW, 1, 1, 0, 0, 0));
    // Elapsed time across the 32-bit wrap: one short, then exactly the delay.
    push_row(CMD_SERVICE, 32'h0000_00F3, 1'b1, 1'b1, word(PH_ON_NEW, 0, 0, 0, 0, 0));
    push_row(CMD_SERVICE, 32'h0000_00F4, 1'b1, 1'b1,
             word(PH_ON_STABLE, 1, 0, 0, 0, 0));
    // Unused command: no effect at all.
    push_row(CMD_UNUSED, 32'h5A5A_5A5A, 1'b0, 1'b1,
             word(PH_ON_STABLE, 0, 0, 0, 0, 0));
    // Fill the ring, then overflow it by one.
    push_row(CMD_ATTACH, 32'hA5A5_A5A5, 1'b1, 1'b1,
             word(PH_ON_STABLE, 0, 0, 1, 1, 0));
    push_row(CMD_REMOVAL, 32'h0000_0100, 1'b0, 1'b1,
             word(PH_ON_STABLE, 0, 0, 1, 1, 0));
    for (int k = 2; k < SLOTS; k++)
      push_row((k % 2 != 0) ? CMD_REMOVAL : CMD_ATTACH, 32'h0000_0100 + k,
               k[0], 1'b0, '0);
    push_row(CMD_ATTACH, 32'h0000_0180, 1'b1, 1'b1, word(PH_ON_STABLE, 0, 0, 0, 1, 0));
    // Drain a full ring ending on removal while supply is present: the
    // largest change count.
    push_row(CMD_SERVICE, 32'h0000_0200, 1'b1, 1'b1,
             word(PH_ON_NEW, SLOTS + 1, 1, 0, 0, 0));
    push_items();
    wait_drained();
    clock_ms = 32'h0000_0200;

    // Random phases, each under its own debounce setting.
    for (int ph = 1; ph <= 6; ph++) begin
      case (ph)
        1: begin
          // Zero delays: the phase must never advance by time.
          cfg[0] = 16'd0;     cfg[1] = 16'd0;     cfg[2] = 16'd0;
        end
        2: begin
          cfg[0] = 16'hFFFF;  cfg[1] = 16'hFFFF;  cfg[2] = 16'hFFFF;
        end
        3: begin
          cfg[0] = 16'd1;     cfg[1] = 16'd1;     cfg[2] = 16'd1;
        end
        6: begin
          cfg[0] = 16'($urandom_range(0, 65535));
          cfg[1] = 16'($urandom_range(0, 65535));
          cfg[2] = 16'($urandom_range(0, 65535));
          cfg[2'($urandom_range(0, 2))] = 16'd0;
        end
        default: begin
          cfg[0] = 16'($urandom_range(0, 2000));
          cfg[1] = 16'($urandom_range(0, 2000));
          cfg[2] = 16'($urandom_range(0, 2000));
        end
      endcase
      write_debounce(REG_OFF_HALF, cfg[0]);
      write_debounce(REG_OFF_STABLE, cfg[1]);
      write_debounce(REG_ON_STABLE, cfg[2]);
      // One phase runs with no idling on either side.
      idle_on = (ph != 3);
      queue_random(130);
      // Hold the receiver off while items keep coming, so the block backs up.
      if (ph == 2) squeeze_req <= 1'b1;
      push_items();
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
